FILE: rtl/mtwq_pkg.sv
// Shared types and status codes for the mutex table with wait queues.
package mtwq_pkg;

    localparam logic [2:0] ST_GRANTED   = 3'd0;
    localparam logic [2:0] ST_QUEUED    = 3'd1;
    localparam logic [2:0] ST_NO_SPACE  = 3'd2;
    localparam logic [2:0] ST_HANDED    = 3'd3;
    localparam logic [2:0] ST_FREED     = 3'd4;
    localparam logic [2:0] ST_UNKNOWN   = 3'd5;
    localparam logic [2:0] ST_NOT_OWNER = 3'd6;

    localparam logic ACT_LOCK   = 1'b0;
    localparam logic ACT_UNLOCK = 1'b1;

    // One request as it travels from front to back
    typedef struct packed {
        logic        action;
        logic [7:0]  thread_id;
        logic [31:0] lock_id;
    } req_t;

endpackage

FILE: rtl/mtwq_front.sv
// Request front end: takes requests and holds them in a short queue for the engine.
module mtwq_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          action,
    input  logic [7:0]    thread_id,
    input  logic [31:0]   lock_id,
    output logic          busy,
    output mtwq_pkg::req_t req,
    output logic          req_valid,
    input  logic          req_take
);
    import mtwq_pkg::*;

    req_t       q_reg [2];
    logic [1:0] cnt_reg;
    logic       wp_reg;
    logic       rp_reg;
    logic       push;

    // Block new requests while the queue is full
    assign busy      = (cnt_reg == 2'd2);
    assign push      = start && !busy;
    assign req_valid = (cnt_reg != 2'd0);
    assign req       = q_reg[rp_reg];

    // Write the request into the queue
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg] <= '{action: action, thread_id: thread_id, lock_id: lock_id};
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (req_take)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, req_take};
        end
    end

    a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
        req_take |-> req_valid) else $error("take from empty queue");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3) else $error("queue count overflow");
    a_full_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2 && !req_take) |=> busy) else $error("full queue not busy");

endmodule

FILE: rtl/mtwq_engine.sv
// Lock engine: slot search, grant, queueing and handover of one request at a time.
module mtwq_engine #(
    parameter int LOCK_SLOTS     = 16,
    parameter int WAITER_ENTRIES = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  mtwq_pkg::req_t req,
    input  logic           req_valid,
    output logic           req_take,
    output logic           done,
    output logic [2:0]     status,
    output logic [7:0]     next_owner,
    output logic [4:0]     free_locks,
    output logic [5:0]     free_waiters
);
    import mtwq_pkg::*;

    localparam int SW = (LOCK_SLOTS > 1) ? $clog2(LOCK_SLOTS) : 1;
    localparam int WW = (WAITER_ENTRIES > 1) ? $clog2(WAITER_ENTRIES) : 1;
    localparam int SC = $clog2(LOCK_SLOTS + 1);
    localparam int WC = $clog2(WAITER_ENTRIES + 1);
    localparam int QL = $clog2(WAITER_ENTRIES + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_DEC  = 3'd2;
    localparam logic [2:0] S_WSCN = 3'd3;
    localparam logic [2:0] S_HAND = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    // Slot table
    logic [LOCK_SLOTS-1:0] used_reg;
    logic [31:0]           key_reg    [LOCK_SLOTS];
    logic [7:0]            holder_reg [LOCK_SLOTS];
    logic [WW-1:0]         head_reg   [LOCK_SLOTS];
    logic [WW-1:0]         tail_reg   [LOCK_SLOTS];
    logic [QL-1:0]         qlen_reg   [LOCK_SLOTS];
    // Waiter pool
    logic [WAITER_ENTRIES-1:0] wused_reg;
    logic [7:0]                wthr_mem  [WAITER_ENTRIES];
    logic [WW-1:0]             wlink_mem [WAITER_ENTRIES];
    logic [7:0]                wthr_rd_reg;
    logic [WW-1:0]             wlink_rd_reg;

    logic [SC-1:0] fs_reg;
    logic [WC-1:0] fw_reg;

    logic [2:0]    state_reg;
    req_t          cur_reg;
    logic [SW:0]   idx_reg;
    logic [WW:0]   widx_reg;
    logic          hit_reg;
    logic [SW-1:0] hit_slot_reg;
    logic          fr_reg;
    logic [SW-1:0] free_slot_reg;
    logic [2:0]    st_reg;
    logic [7:0]    nx_reg;

    logic [SW-1:0] si;
    logic [WW-1:0] wi;
    assign si = idx_reg[SW-1:0];
    assign wi = widx_reg[WW-1:0];

    assign req_take     = (state_reg == S_IDLE) && req_valid;
    assign done         = (state_reg == S_DONE);
    assign status       = st_reg;
    assign next_owner   = nx_reg;
    assign free_locks   = 5'(fs_reg);
    assign free_waiters = 6'(fw_reg);

    // Waiter memory: registered read of head entry
    always_ff @(posedge clk)
    begin
        wthr_rd_reg  <= wthr_mem[head_reg[hit_slot_reg]];
        wlink_rd_reg <= wlink_mem[head_reg[hit_slot_reg]];
        if (state_reg == S_WSCN && !wused_reg[wi])
        begin
            wthr_mem[wi]  <= cur_reg.thread_id;
            wlink_mem[wi] <= '0;
        end
        if (state_reg == S_WSCN && !wused_reg[wi] && qlen_reg[hit_slot_reg] != '0)
        begin
            wlink_mem[tail_reg[hit_slot_reg]] <= wi;
        end
    end

    // Slot payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_DEC && cur_reg.action == ACT_LOCK && !hit_reg && fr_reg
            && fs_reg != '0)
        begin
            holder_reg[free_slot_reg] <= cur_reg.thread_id;
        end
        if (state_reg == S_WSCN && !wused_reg[wi])
        begin
            if (qlen_reg[hit_slot_reg] == '0)
            begin
                head_reg[hit_slot_reg] <= wi;
            end
            tail_reg[hit_slot_reg] <= wi;
        end
        if (state_reg == S_HAND)
        begin
            holder_reg[hit_slot_reg] <= wthr_rd_reg;
            head_reg[hit_slot_reg]   <= wlink_rd_reg;
        end
    end

    // Control sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            wused_reg     <= '0;
            fs_reg        <= SC'(LOCK_SLOTS);
            fw_reg        <= WC'(WAITER_ENTRIES);
            for (int i = 0; i < LOCK_SLOTS; i++)
            begin
                key_reg[i]  <= '0;
                qlen_reg[i] <= '0;
            end
            cur_reg       <= '0;
            idx_reg       <= '0;
            widx_reg      <= '0;
            hit_reg       <= 1'b0;
            hit_slot_reg  <= '0;
            fr_reg        <= 1'b0;
            free_slot_reg <= '0;
            st_reg        <= ST_GRANTED;
            nx_reg        <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        cur_reg   <= req;
                        idx_reg   <= '0;
                        hit_reg   <= 1'b0;
                        fr_reg    <= 1'b0;
                        nx_reg    <= '0;
                        state_reg <= S_SCAN;
                    end
                end
                // Scan one slot a cycle for key match and lowest free slot
                S_SCAN:
                begin
                    if (used_reg[si] && key_reg[si] == cur_reg.lock_id && !hit_reg)
                    begin
                        hit_reg      <= 1'b1;
                        hit_slot_reg <= si;
                    end
                    if (!used_reg[si] && !fr_reg)
                    begin
                        fr_reg        <= 1'b1;
                        free_slot_reg <= si;
                    end
                    if (idx_reg == (SW+1)'(LOCK_SLOTS - 1))
                    begin
                        state_reg <= S_DEC;
                    end
                    idx_reg <= idx_reg + 1'b1;
                end
                S_DEC:
                begin
                    state_reg <= S_DONE;
                    if (cur_reg.action == ACT_LOCK)
                    begin
                        if (hit_reg)
                        begin
                            if (fw_reg == '0)
                            begin
                                st_reg <= ST_NO_SPACE;
                            end
                            else
                            begin
                                widx_reg  <= '0;
                                state_reg <= S_WSCN;
                            end
                        end
                        else if (fs_reg == '0 || !fr_reg)
                        begin
                            st_reg <= ST_NO_SPACE;
                        end
                        else
                        begin
                            used_reg[free_slot_reg] <= 1'b1;
                            key_reg[free_slot_reg]  <= cur_reg.lock_id;
                            qlen_reg[free_slot_reg] <= '0;
                            fs_reg <= fs_reg - 1'b1;
                            st_reg <= ST_GRANTED;
                        end
                    end
                    else if (!hit_reg)
                    begin
                        st_reg <= ST_UNKNOWN;
                    end
                    else if (holder_reg[hit_slot_reg] != cur_reg.thread_id)
                    begin
                        st_reg <= ST_NOT_OWNER;
                    end
                    else if (qlen_reg[hit_slot_reg] != '0)
                    begin
                        state_reg <= S_HAND;
                    end
                    else
                    begin
                        used_reg[hit_slot_reg] <= 1'b0;
                        key_reg[hit_slot_reg]  <= '0;
                        fs_reg <= fs_reg + 1'b1;
                        st_reg <= ST_FREED;
                    end
                end
                // Find the lowest free waiter entry and link it at the tail
                S_WSCN:
                begin
                    if (!wused_reg[wi])
                    begin
                        wused_reg[wi] <= 1'b1;
                        fw_reg <= fw_reg - 1'b1;
                        qlen_reg[hit_slot_reg] <= qlen_reg[hit_slot_reg] + 1'b1;
                        st_reg    <= ST_QUEUED;
                        state_reg <= S_DONE;
                    end
                    else if (widx_reg == (WW+1)'(WAITER_ENTRIES - 1))
                    begin
                        st_reg    <= ST_NO_SPACE;
                        state_reg <= S_DONE;
                    end
                    widx_reg <= widx_reg + 1'b1;
                end
                // Pass the lock to the oldest waiter
                S_HAND:
                begin
                    wused_reg[head_reg[hit_slot_reg]] <= 1'b0;
                    qlen_reg[hit_slot_reg] <= qlen_reg[hit_slot_reg] - 1'b1;
                    fw_reg    <= fw_reg + 1'b1;
                    nx_reg    <= wthr_rd_reg;
                    st_reg    <= ST_HANDED;
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_fs_range: assert property (@(posedge clk) disable iff (!rst_n)
        fs_reg <= SC'(LOCK_SLOTS)) else $error("free slot count out of range");
    a_fw_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(wused_reg) + fw_reg == WAITER_ENTRIES) else $error("waiter count mismatch");
    a_fs_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(used_reg) + fs_reg == LOCK_SLOTS) else $error("slot count mismatch");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("result held two cycles");
    a_nx_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && st_reg != ST_HANDED) |-> nx_reg == '0) else $error("next owner not zero");

endmodule

FILE: rtl/mutex_table_with_wait_queues_unit.sv
// Top level of the mutex table with FIFO wait queues.
// Usage: drive action, thread_id and lock_id with start; a request is taken
// at a rising edge where start is high and busy is low. A two-entry request
// queue sits in front of the lock engine, so up to two requests may be
// taken while the engine works.
// Each request gives exactly one result on status, next_owner, free_locks
// and free_waiters, marked by done for one cycle; the receiver cannot stall.
// The slot-by-slot key search over every slot sets the pace for each request;
// a handover adds a step, and a queued lock takes longer still while
// queueing scans the waiter pool. The engine works on one request at a time.
// Reset empties all slots and waiters; the free counts start at LOCK_SLOTS
// and WAITER_ENTRIES. No clearing pass is needed.
module mutex_table_with_wait_queues_unit #(
    parameter int LOCK_SLOTS     = 16,
    parameter int WAITER_ENTRIES = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        action,
    input  logic [7:0]  thread_id,
    input  logic [31:0] lock_id,
    output logic        done,
    output logic [2:0]  status,
    output logic [7:0]  next_owner,
    output logic [4:0]  free_locks,
    output logic [5:0]  free_waiters
);
    import mtwq_pkg::*;

    req_t req;
    logic req_valid;
    logic req_take;

    mtwq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .action    (action),
        .thread_id (thread_id),
        .lock_id   (lock_id),
        .busy      (busy),
        .req       (req),
        .req_valid (req_valid),
        .req_take  (req_take)
    );

    mtwq_engine #(
        .LOCK_SLOTS     (LOCK_SLOTS),
        .WAITER_ENTRIES (WAITER_ENTRIES)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req),
        .req_valid    (req_valid),
        .req_take     (req_take),
        .done         (done),
        .status       (status),
        .next_owner   (next_owner),
        .free_locks   (free_locks),
        .free_waiters (free_waiters)
    );

endmodule
